FILE: hdl/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types, register indexes and pixel formatting for the TGA decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

    localparam int SKIP_W   = 19;
    localparam int DIM_W    = 16;
    localparam int PIX_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 19;

    // Depth codes; anything above DEPTH_32 decodes as 24 bit
    localparam logic [2:0] DEPTH_8  = 3'd0;
    localparam logic [2:0] DEPTH_15 = 3'd1;
    localparam logic [2:0] DEPTH_16 = 3'd2;
    localparam logic [2:0] DEPTH_24 = 3'd3;
    localparam logic [2:0] DEPTH_32 = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

    localparam logic [7:0] RUN_HDR_MIN = 8'd128;
    localparam logic [7:0] RUN_BIAS    = 8'd127;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_colour;

    typedef struct packed {
        logic       last;
        logic [7:0] run_length;
        t_colour    colour;
    } t_out_item;

    function automatic logic [2:0] bytes_per_pixel(input logic [2:0] depth);
        logic [2:0] n;
        unique case (depth)
            DEPTH_8:  n = 3'd1;
            DEPTH_15: n = 3'd2;
            DEPTH_16: n = 3'd2;
            DEPTH_32: n = 3'd4;
            default:  n = 3'd3;
        endcase
        return n;
    endfunction

    // all: earlier bytes of the pixel, b: final byte
    function automatic t_colour format_pixel(input logic [2:0]  depth,
                                             input logic [23:0] all,
                                             input logic [7:0]  b);
        t_colour    c;
        logic [15:0] src;
        src = {b, all[7:0]};
        unique case (depth)
            DEPTH_8: begin
                c = '{alpha: 8'd0, red: 8'd0, green: 8'd0, blue: b};
            end
            DEPTH_15, DEPTH_16: begin
                c.red   = {src[14:10], 3'd0};
                c.green = {src[9:5], 3'd0};
                c.blue  = {src[4:0], 3'd0};
                c.alpha = (depth == DEPTH_16) ? {src[15], 7'd0} : 8'hFF;
            end
            DEPTH_32: begin
                c = '{alpha: b, red: all[23:16], green: all[15:8], blue: all[7:0]};
            end
            default: begin
                c = '{alpha: 8'hFF, red: b, green: all[15:8], blue: all[7:0]};
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/tga_out_skid.sv
// ----------------------------------------------------------------------------
// tga_out_skid
// Output register with one skid entry, so upstream keeps going for one
// transfer while the consumer stalls.
// ----------------------------------------------------------------------------
module tga_out_skid
    import tga_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_ready
);

    logic      r_valid;
    logic      r_skid_valid;
    t_out_item r_item;
    t_out_item r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_valid && !i_ready) begin
            // stalled: park a new result in the skid entry
            if (i_push) begin
                r_skid       <= i_item;
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_item       <= r_skid;
            r_valid      <= 1'b1;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_item  <= i_item;
            r_valid <= 1'b1;
        end else begin
            r_valid <= 1'b0;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hdl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decodes the byte stream of a TGA image body into pixels with run counts.
//
//   channel   direction  signals                         contents
//   s (bytes) in         i_s_tvalid/o_s_tready/i_s_tdata one image byte
//   m (pixel) out        o_m_tvalid/i_m_tready/o_m_tdata pixel + run, tlast
//   cfg       in         i_cfg_valid/o_cfg_ready         register index, data
//
// One byte per cycle; each byte updates the packet and assembly registers in
// a single pass and a completed pixel lands in the output register, or in the
// skid entry while the output stalls. A write to a defined register index
// restarts the stream; byte input is held off while the image size product is
// loaded. Reset is synchronous, active low. Output stalls are absorbed by one
// skid entry; the byte input stops while it is occupied or a restart is pending.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
    import tga_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] data_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [39:0]          o_m_tdata,   // run_length, alpha, red, green, blue (MSB first)
    output logic                 o_m_tlast,   // last_of_image
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // configuration
    logic [SKIP_W-1:0] r_skip_bytes;
    logic [2:0]        r_depth;
    logic              r_rle;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic              r_reload;

    // stream state
    logic [SKIP_W-1:0] r_skip_left, n_skip_left;
    logic [1:0]        r_phase,     n_phase;
    logic [23:0]       r_partial,   n_partial;
    logic [7:0]        r_pkt_left,  n_pkt_left;
    logic              r_pkt_run,   n_pkt_run;
    logic [PIX_W-1:0]  r_pix_left,  n_pix_left;

    logic       w_accept;
    logic       w_cfg_wr;
    logic       w_push;
    logic       w_full;
    t_out_item  w_item;
    t_out_item  w_out;
    logic [7:0] w_run;
    logic [PIX_W-1:0] w_total;

    assign w_cfg_wr    = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_reload && !w_full;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_total     = {16'd0, r_width} * {16'd0, r_height};

    always_comb begin
        n_skip_left = r_skip_left;
        n_phase     = r_phase;
        n_partial   = r_partial;
        n_pkt_left  = r_pkt_left;
        n_pkt_run   = r_pkt_run;
        n_pix_left  = r_pix_left;
        w_push      = 1'b0;
        w_run       = 8'd1;
        w_item.colour     = format_pixel(r_depth, r_partial, i_s_tdata);
        w_item.run_length = 8'd1;
        w_item.last       = 1'b0;

        if (w_accept && r_pix_left != '0) begin
            if (r_skip_left != '0) begin
                n_skip_left = r_skip_left - SKIP_W'(1);
            end else if (r_rle && r_pkt_left == 8'd0 && r_phase == 2'd0) begin
                // packet header
                if (i_s_tdata >= RUN_HDR_MIN) begin
                    n_pkt_run  = 1'b1;
                    n_pkt_left = i_s_tdata - RUN_BIAS;
                end else begin
                    n_pkt_run  = 1'b0;
                    n_pkt_left = i_s_tdata + 8'd1;
                end
            end else if (({1'b0, r_phase} + 3'd1) < bytes_per_pixel(r_depth)) begin
                case (r_phase)
                    2'd0:    n_partial[7:0]   = i_s_tdata;
                    2'd1:    n_partial[15:8]  = i_s_tdata;
                    default: n_partial[23:16] = i_s_tdata;
                endcase
                n_phase = r_phase + 2'd1;
            end else begin
                n_phase   = 2'd0;
                n_partial = '0;
                if (r_rle) begin
                    if (r_pkt_run) begin
                        w_run      = r_pkt_left;
                        n_pkt_left = 8'd0;
                    end else begin
                        n_pkt_left = r_pkt_left - 8'd1;
                    end
                end
                // clip a run at the image end
                if ({24'd0, w_run} > r_pix_left) begin
                    w_run = r_pix_left[7:0];
                end
                n_pix_left        = r_pix_left - {24'd0, w_run};
                w_item.run_length = w_run;
                w_item.last       = (n_pix_left == '0);
                w_push            = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_bytes <= '0;
            r_depth      <= DEPTH_24;
            r_rle        <= 1'b0;
            r_width      <= 16'd1;
            r_height     <= 16'd1;
            r_reload     <= 1'b0;
            r_skip_left  <= '0;
            r_phase      <= 2'd0;
            r_partial    <= '0;
            r_pkt_left   <= 8'd0;
            r_pkt_run    <= 1'b0;
            r_pix_left   <= 32'd1;
        end else begin
            r_skip_left <= n_skip_left;
            r_phase     <= n_phase;
            r_partial   <= n_partial;
            r_pkt_left  <= n_pkt_left;
            r_pkt_run   <= n_pkt_run;
            r_pix_left  <= n_pix_left;
            r_reload    <= 1'b0;

            // restart with the new settings once the size product settles
            if (r_reload) begin
                r_skip_left <= r_skip_bytes;
                r_phase     <= 2'd0;
                r_partial   <= '0;
                r_pkt_left  <= 8'd0;
                r_pkt_run   <= 1'b0;
                r_pix_left  <= w_total;
            end

            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_SKIP: begin
                        r_skip_bytes <= i_cfg_data;
                        r_reload     <= 1'b1;
                    end
                    CFG_DEPTH: begin
                        r_depth  <= i_cfg_data[2:0];
                        r_reload <= 1'b1;
                    end
                    CFG_RLE: begin
                        r_rle    <= i_cfg_data[0];
                        r_reload <= 1'b1;
                    end
                    CFG_WIDTH: begin
                        r_width  <= i_cfg_data[DIM_W-1:0];
                        r_reload <= 1'b1;
                    end
                    CFG_HEIGHT: begin
                        r_height <= i_cfg_data[DIM_W-1:0];
                        r_reload <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    tga_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .o_valid (o_m_tvalid),
        .o_item  (w_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {w_out.run_length, w_out.colour.alpha, w_out.colour.red,
                        w_out.colour.green, w_out.colour.blue};
    assign o_m_tlast = w_out.last;

`ifndef SYNTHESIS
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("result pushed while skid entry occupied");

    a_cfg_holds_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && i_cfg_index == CFG_WIDTH) |=> !o_s_tready)
        else $error("byte input taken before restart completed");

    a_silent_after_image : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pix_left == '0) |-> !w_push)
        else $error("result produced after image end");

    a_last_run_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_item.run_length != 8'd0 && w_item.run_length <= 8'd128))
        else $error("run length out of range");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TGA pixel decoder. Image byte streams, mostly
// well-formed packet and pixel sequences with random content, are pushed
// through the byte channel. A behavioural decoder predicts every pixel
// transfer and the output channel is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_top
    import tga_pkg::*;
();

    localparam int SKIP_MAX   = 262395;
    localparam int DIM_MAX    = 65535;
    localparam int PLAN_CAP   = 160;     // bytes per image plan
    localparam int ITEM_GOAL  = 1550;
    localparam int SETTLE_CYC = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_HEIGHT + 3'd1;

    // ------------------------------------------------------------------------
    // Behavioural decoder and store of expected pixels
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        logic [18:0] skip_reg;
        logic [2:0]  depth_reg;
        logic        rle_reg;
        logic [15:0] width_reg;
        logic [15:0] height_reg;

        logic [18:0] skip_left;
        logic [1:0]  byte_idx;
        logic [23:0] held_bytes;
        logic [7:0]  packet_left;
        logic        packet_run;
        logic [31:0] pixels_left;

        t_out_item expected_pixels[$];
        int        errors;

        function new();
            skip_reg   = '0;
            depth_reg  = DEPTH_24;
            rle_reg    = 1'b0;
            width_reg  = 16'd1;
            height_reg = 16'd1;
            errors     = 0;
            rewind_stream();
        endfunction

        function void rewind_stream();
            skip_left   = skip_reg;
            byte_idx    = '0;
            held_bytes  = '0;
            packet_left = '0;
            packet_run  = 1'b0;
            pixels_left = 32'(width_reg) * 32'(height_reg);
        endfunction

        function int pixel_bytes();
            case (depth_reg)
                DEPTH_8:            return 1;
                DEPTH_15, DEPTH_16: return 2;
                DEPTH_32:           return 4;
                default:            return 3;
            endcase
        endfunction

        // unused indexes change nothing and do not restart the stream
        function void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
            case (idx)
                CFG_SKIP:   skip_reg   = value;
                CFG_DEPTH:  depth_reg  = value[2:0];
                CFG_RLE:    rle_reg    = value[0];
                CFG_WIDTH:  width_reg  = value[15:0];
                CFG_HEIGHT: height_reg = value[15:0];
                default:    return;
            endcase
            rewind_stream();
        endfunction

        // returns 1 when the byte was decoded (header or pixel byte)
        function bit take_byte(logic [7:0] b);
            t_out_item   px;
            logic [15:0] pair;
            int          run;
            if (pixels_left == 0)
                return 0;
            if (skip_left != 0) begin
                skip_left--;
                return 0;
            end
            if (rle_reg && packet_left == 0 && byte_idx == 0) begin
                packet_run  = (b >= RUN_HDR_MIN);
                packet_left = packet_run ? b - RUN_BIAS : b + 8'd1;
                return 1;
            end
            if (int'(byte_idx) + 1 < pixel_bytes()) begin
                held_bytes = held_bytes | (24'(b) << (8 * byte_idx));
                byte_idx++;
                return 1;
            end

            pair = {b, held_bytes[7:0]};
            case (depth_reg)
                DEPTH_8: begin
                    px.colour.blue  = b;
                    px.colour.green = 8'd0;
                    px.colour.red   = 8'd0;
                    px.colour.alpha = 8'd0;
                end
                DEPTH_15, DEPTH_16: begin
                    px.colour.red   = {pair[14:10], 3'd0};
                    px.colour.green = {pair[9:5], 3'd0};
                    px.colour.blue  = {pair[4:0], 3'd0};
                    px.colour.alpha = (depth_reg == DEPTH_16) ? {pair[15], 7'd0} : 8'hFF;
                end
                DEPTH_32: begin
                    px.colour.blue  = held_bytes[7:0];
                    px.colour.green = held_bytes[15:8];
                    px.colour.red   = held_bytes[23:16];
                    px.colour.alpha = b;
                end
                default: begin
                    px.colour.blue  = held_bytes[7:0];
                    px.colour.green = held_bytes[15:8];
                    px.colour.red   = b;
                    px.colour.alpha = 8'hFF;
                end
            endcase
            byte_idx   = '0;
            held_bytes = '0;

            run = 1;
            if (rle_reg) begin
                if (packet_run) begin
                    run         = int'(packet_left);
                    packet_left = '0;
                end else begin
                    packet_left--;
                end
            end
            // runs are clipped at the end of the image
            if (32'(run) > pixels_left)
                run = int'(pixels_left);
            pixels_left    = pixels_left - 32'(run);
            px.run_length  = 8'(run);
            px.last        = (pixels_left == 0);
            expected_pixels.push_back(px);
            return 1;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(logic [39:0] data, logic last);
            t_out_item want;
            if (expected_pixels.size() == 0) begin
                $error("pixel transfer with nothing expected: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("blue", want.colour.blue, data[7:0]);
            compare_field("green", want.colour.green, data[15:8]);
            compare_field("red", want.colour.red, data[23:16]);
            compare_field("alpha", want.colour.alpha, data[31:24]);
            compare_field("run_length", want.run_length, data[39:32]);
            compare_field("last_of_image", want.last, last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clocking
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [39:0]          o_m_tdata;
    logic                 o_m_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    pixel_scoreboard sb;
    logic [7:0]      byte_plan[$];
    int              decoded_bytes;

    tga_rle_pixel_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly back to back, a few long holes
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // pixel sink with random stalls
    initial begin
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_pixel(o_m_tdata, o_m_tlast);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (sb.take_byte(value))
            decoded_bytes++;
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_reg_write(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // idle the byte side and let every expected pixel out before moving on
    task automatic settle_stream();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic send_plan();
        bit calm;
        calm = ($urandom_range(0, 4) == 0);
        foreach (byte_plan[i])
            send_byte(byte_plan[i], calm ? 0 : pick_gap());
        settle_stream();
    endtask

    // ------------------------------------------------------------------------
    // Random images
    // ------------------------------------------------------------------------
    task automatic push_pixel(input int nbytes);
        repeat (nbytes) byte_plan.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic pick_config();
        int r;
        if ($urandom_range(0, 2) != 0)
            program_reg(CFG_SKIP, CFG_DAT_W'(($urandom_range(0, 3) == 0) ?
                                             $urandom_range(1, 8) : 0));
        if ($urandom_range(0, 2) != 0)
            program_reg(CFG_DEPTH, CFG_DAT_W'(($urandom_range(0, 6) == 0) ?
                                              DEPTH_32 + $urandom_range(1, 3) :
                                              $urandom_range(DEPTH_8, DEPTH_32)));
        if ($urandom_range(0, 2) != 0)
            program_reg(CFG_RLE, CFG_DAT_W'($urandom_range(0, 2) != 0));
        if ($urandom_range(0, 2) != 0) begin
            r = $urandom_range(0, 99);
            program_reg(CFG_WIDTH, CFG_DAT_W'((r < 80) ? $urandom_range(1, 6) :
                                              (r < 96) ? $urandom_range(7, 40) :
                                              (r < 98) ? DIM_MAX : $urandom_range(41, DIM_MAX)));
        end
        if ($urandom_range(0, 2) != 0) begin
            r = $urandom_range(0, 99);
            program_reg(CFG_HEIGHT, CFG_DAT_W'((r < 80) ? $urandom_range(1, 4) :
                                               (r < 96) ? $urandom_range(5, 20) :
                                               (r < 98) ? DIM_MAX : $urandom_range(21, DIM_MAX)));
        end
        if ($urandom_range(0, 19) == 0)
            program_reg(CFG_IDX_W'(CFG_HEIGHT + $urandom_range(1, 3)),
                        CFG_DAT_W'($urandom()));
    endtask

    // well-formed image for the current settings, sometimes cut short or noise
    task automatic plan_image();
        longint left;
        int     bpp;
        int     n;
        byte_plan.delete();
        for (int i = 0; i < int'(sb.skip_reg) && i < PLAN_CAP; i++)
            byte_plan.push_back(8'($urandom_range(0, 255)));
        left = longint'(sb.width_reg) * longint'(sb.height_reg);
        bpp  = sb.pixel_bytes();
        while (left > 0 && byte_plan.size() < PLAN_CAP) begin
            if (sb.rle_reg) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
                if ($urandom_range(0, 1) != 0) begin
                    byte_plan.push_back(8'(RUN_BIAS + n));
                    push_pixel(bpp);
                    left -= (n < left) ? n : left;
                end else begin
                    byte_plan.push_back(8'(n - 1));
                    for (int k = 0; k < n && left > 0; k++) begin
                        push_pixel(bpp);
                        left--;
                    end
                end
            end else begin
                push_pixel(bpp);
                left--;
            end
        end
        repeat ($urandom_range(0, 3)) byte_plan.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0 && byte_plan.size() > 1)
            byte_plan = byte_plan[0:$urandom_range(0, byte_plan.size() - 2)];
        if ($urandom_range(0, 19) == 0) begin
            byte_plan.delete();
            repeat ($urandom_range(4, 40)) byte_plan.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb            = new();
        decoded_bytes = 0;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SKIP;
        i_cfg_data    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one 24-bit pixel, then the image is done
        byte_plan = '{8'h00, 8'hFF, 8'h80, 8'h3C};
        send_plan();

        // 8-bit, packet coded, 2x2 behind two dropped bytes; run of 128 clipped
        program_reg(CFG_SKIP, CFG_DAT_W'(2));
        program_reg(CFG_DEPTH, CFG_DAT_W'(DEPTH_8));
        program_reg(CFG_RLE, CFG_DAT_W'(1));
        program_reg(CFG_WIDTH, CFG_DAT_W'(2));
        program_reg(CFG_HEIGHT, CFG_DAT_W'(2));
        byte_plan = '{8'hAA, 8'h55, 8'hFF, 8'h00};
        send_plan();

        // unused index must not restart a finished image
        program_reg(CFG_UNUSED, CFG_DAT_W'(0));
        byte_plan = '{8'h77};
        send_plan();

        // 15-bit: raw packet of one, then a run of three
        program_reg(CFG_SKIP, CFG_DAT_W'(0));
        program_reg(CFG_DEPTH, CFG_DAT_W'(DEPTH_15));
        byte_plan = '{8'h00, 8'hFF, 8'hFF, 8'h82, 8'h00, 8'h7C};
        send_plan();

        // 16-bit, uncoded: alpha from bit 15
        program_reg(CFG_DEPTH, CFG_DAT_W'(DEPTH_16));
        program_reg(CFG_RLE, CFG_DAT_W'(0));
        program_reg(CFG_HEIGHT, CFG_DAT_W'(1));
        byte_plan = '{8'h00, 8'h80, 8'hFF, 8'h7F};
        send_plan();

        program_reg(CFG_DEPTH, CFG_DAT_W'(DEPTH_32));
        program_reg(CFG_WIDTH, CFG_DAT_W'(1));
        byte_plan = '{8'h7F, 8'h80, 8'h01, 8'hFE};
        send_plan();

        // undefined depth code decodes as 24 bit
        program_reg(CFG_DEPTH, CFG_DAT_W'(DEPTH_32 + 3));
        byte_plan = '{8'h11, 8'h22, 8'h33};
        send_plan();

        // empty image swallows everything
        program_reg(CFG_WIDTH, CFG_DAT_W'(0));
        byte_plan = '{8'h9C};
        send_plan();

        program_reg(CFG_WIDTH, CFG_DAT_W'(DIM_MAX));
        program_reg(CFG_HEIGHT, CFG_DAT_W'(DIM_MAX));
        program_reg(CFG_SKIP, CFG_DAT_W'(SKIP_MAX));
        byte_plan = '{8'hC3, 8'h3C};
        send_plan();
        program_reg(CFG_SKIP, CFG_DAT_W'(0));

        while (decoded_bytes < ITEM_GOAL) begin
            pick_config();
            plan_image();
            send_plan();
        end

        settle_stream();
        if (sb.errors == 0 && sb.expected_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
